[src/two_key_debounce_autorepeat_macros.svh]
// Assertion helpers shared by the RTL; clocked on clk, disabled in reset.
`ifndef TWO_KEY_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define TWO_KEY_DEBOUNCE_AUTOREPEAT_MACROS_SVH

// Check cons in the same cycle as ante.
`define TKDA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define TKDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/tkda_pkg.sv]
`default_nettype none

package tkda_pkg;

	localparam int NOW_W      = 32;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;
	localparam int ADDR_W     = 4;
	localparam int APB_DATA_W = 32;
	localparam int CNT_W      = 4;
	localparam int MS_W       = 16;
	localparam int NUM_KEYS   = 2;

	localparam int KEY_UP   = 0;
	localparam int KEY_DOWN = 1;

	localparam logic [CNT_W-1:0] THRESHOLD_RST  = 4'd3;
	localparam logic [MS_W-1:0]  LONG_PRESS_RST = 16'd500;
	localparam logic [MS_W-1:0]  REPEAT_RST     = 16'd120;

	typedef enum logic [1:0] {
		REG_PRESS_LEVEL = 2'd0,
		REG_THRESHOLD   = 2'd1,
		REG_LONG_PRESS  = 2'd2,
		REG_REPEAT      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             press_level;
		logic [CNT_W-1:0] threshold;
		logic [MS_W-1:0]  long_press;
		logic [MS_W-1:0]  repeat_ms;
	} cfg_t;

endpackage

`default_nettype wire

[src/two_key_debounce_autorepeat.sv]
`default_nettype none

// Two-key debouncer with long-press auto-repeat. Each request on the s_ side is one poll of
// an up key and a down key with a millisecond timestamp; each poll gives exactly one result
// on the m_ side, a step bit per key. A key's pressed state flips only after
// debounce_threshold equal samples; a change to pressed steps at once, a held key steps again
// after long_press_ms and then every repeat_ms, with time differences taken modulo
// 2^TIME_BITS. A key whose valid bit is low is left untouched and gives no step. One poll is
// accepted every cycle unless the m_ side stalls; a result passes the input register, then
// the result register; the per-key update between them is two TIME_BITS-wide subtracts and
// compares. Registers sit on an APB port at byte addresses 0, 4, 8 and 12; the user must
// write them only while no poll is in flight, which the block itself does not enforce.

`include "two_key_debounce_autorepeat_macros.svh"

module two_key_debounce_autorepeat
	import tkda_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// [0] up_level, [1] up_valid, [2] down_level, [3] down_valid, [35:4] now_ms, [39:36] zero
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [0] up_step, [1] down_step, [7:2] zero
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_W-1:0]     paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	cfg_t                 cfg_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	logic                 in_valid_s1;
	logic [NUM_KEYS-1:0]  level_s1;
	logic [NUM_KEYS-1:0]  valid_s1;
	logic [NOW_W-1:0]     now_s1;
	logic                 advance;
	logic [TIME_BITS-1:0] now_t;

	logic [NUM_KEYS-1:0]  step_s2;

	logic [NUM_KEYS-1:0]  stable_q;
	logic [NUM_KEYS-1:0]  prev_q;
	logic [CNT_W-1:0]     cnt_q      [NUM_KEYS];
	logic [NUM_KEYS-1:0]  rep_q;
	logic [TIME_BITS-1:0] press_q    [NUM_KEYS];
	logic [TIME_BITS-1:0] rtime_q    [NUM_KEYS];

	logic [NUM_KEYS-1:0]  stable_n;
	logic [NUM_KEYS-1:0]  prev_n;
	logic [CNT_W-1:0]     cnt_n      [NUM_KEYS];
	logic [NUM_KEYS-1:0]  rep_n;
	logic [TIME_BITS-1:0] press_n    [NUM_KEYS];
	logic [TIME_BITS-1:0] rtime_n    [NUM_KEYS];
	logic [NUM_KEYS-1:0]  step_n;
	logic [NUM_KEYS-1:0]  upd;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level <= 1'b0;
			cfg_q.threshold   <= THRESHOLD_RST;
			cfg_q.long_press  <= LONG_PRESS_RST;
			cfg_q.repeat_ms   <= REPEAT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PRESS_LEVEL: cfg_q.press_level <= pwdata[0];
				REG_THRESHOLD:   cfg_q.threshold   <= pwdata[CNT_W-1:0];
				REG_LONG_PRESS:  cfg_q.long_press  <= pwdata[MS_W-1:0];
				REG_REPEAT:      cfg_q.repeat_ms   <= pwdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_PRESS_LEVEL: prdata = APB_DATA_W'(cfg_q.press_level);
			REG_THRESHOLD:   prdata = APB_DATA_W'(cfg_q.threshold);
			REG_LONG_PRESS:  prdata = APB_DATA_W'(cfg_q.long_press);
			REG_REPEAT:      prdata = APB_DATA_W'(cfg_q.repeat_ms);
			default:         prdata = '0;
		endcase
	end

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1[KEY_UP]   <= s_tdata[0];
			valid_s1[KEY_UP]   <= s_tdata[1];
			level_s1[KEY_DOWN] <= s_tdata[2];
			valid_s1[KEY_DOWN] <= s_tdata[3];
			now_s1             <= s_tdata[NOW_W+3:4];
		end
	end

	assign now_t = TIME_BITS'(now_s1);

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		logic                 raw;
		logic                 hold;
		logic [TIME_BITS-1:0] held_for;
		logic [TIME_BITS-1:0] since_rep;

		assign raw       = (level_s1[k] == cfg_q.press_level);
		assign held_for  = now_t - press_q[k];
		assign since_rep = now_t - rtime_q[k];
		assign upd[k]    = advance && in_valid_s1 && valid_s1[k];

		always_comb begin
			prev_n[k]   = prev_q[k];
			cnt_n[k]    = cnt_q[k];
			stable_n[k] = stable_q[k];
			rep_n[k]    = rep_q[k];
			press_n[k]  = press_q[k];
			rtime_n[k]  = rtime_q[k];
			step_n[k]   = 1'b0;

			if (raw == prev_q[k]) begin
				if (cnt_q[k] < cfg_q.threshold) begin
					cnt_n[k] = cnt_q[k] + 4'd1;
				end
			end else begin
				prev_n[k] = raw;
				cnt_n[k]  = 4'd1;
			end

			hold = (cnt_n[k] < cfg_q.threshold) || (raw == stable_q[k]);

			if (hold) begin
				if (stable_q[k] && !rep_q[k]) begin
					if (held_for >= TIME_BITS'(cfg_q.long_press)) begin
						rep_n[k]   = 1'b1;
						rtime_n[k] = now_t;
						step_n[k]  = 1'b1;
					end
				end else if (stable_q[k] && rep_q[k]) begin
					if (since_rep >= TIME_BITS'(cfg_q.repeat_ms)) begin
						rtime_n[k] = now_t;
						step_n[k]  = 1'b1;
					end
				end
			end else begin
				stable_n[k] = raw;
				rep_n[k]    = 1'b0;
				press_n[k]  = now_t;
				rtime_n[k]  = now_t;
				step_n[k]   = raw;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stable_q[k] <= 1'b0;
				prev_q[k]   <= 1'b0;
				cnt_q[k]    <= '0;
				rep_q[k]    <= 1'b0;
				press_q[k]  <= '0;
				rtime_q[k]  <= '0;
			end else if (upd[k]) begin
				stable_q[k] <= stable_n[k];
				prev_q[k]   <= prev_n[k];
				cnt_q[k]    <= cnt_n[k];
				rep_q[k]    <= rep_n[k];
				press_q[k]  <= press_n[k];
				rtime_q[k]  <= rtime_n[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance && in_valid_s1) begin
				step_s2[k] <= upd[k] && step_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= in_valid_s1;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-NUM_KEYS){1'b0}}, step_s2};

	`TKDA_ASSERT_SAME(a_up_rep_stable, rep_q[KEY_UP], stable_q[KEY_UP], "up repeating while released")
	`TKDA_ASSERT_SAME(a_dn_rep_stable, rep_q[KEY_DOWN], stable_q[KEY_DOWN], "down repeating while released")
	`TKDA_ASSERT_SAME(a_up_press_step, $rose(stable_q[KEY_UP]), m_tvalid && step_s2[KEY_UP], "up press gave no step")
	`TKDA_ASSERT_NEXT(a_up_skip_quiet, advance && in_valid_s1 && !valid_s1[KEY_UP], !step_s2[KEY_UP], "step on failed up read")
	`TKDA_ASSERT_NEXT(a_s1_hold, in_valid_s1 && !advance, in_valid_s1 && $stable(now_s1), "stalled request lost")

endmodule

`default_nettype wire

[dv/two_key_debounce_autorepeat_test.sv]
`default_nettype none

module two_key_debounce_autorepeat_test
	import tkda_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_OFF_CYCLES = 200;
	localparam int DRAIN_CYCLES    = 6;

	typedef struct packed {
		logic             stable;
		logic             prev_pressed;
		logic [CNT_W-1:0] agree;
		logic             repeating;
		logic [NOW_W-1:0] press_t;
		logic [NOW_W-1:0] repeat_t;
	} key_track_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	wire logic             s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	wire logic             m_tvalid;
	logic                  m_tready = 1'b0;
	wire logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [ADDR_W-1:0]     paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	wire logic [APB_DATA_W-1:0] prdata;
	wire logic             pready;

	key_track_t       key_st [NUM_KEYS];
	logic             cfg_active;
	logic [CNT_W-1:0] cfg_thresh;
	logic [MS_W-1:0]  cfg_long;
	logic [MS_W-1:0]  cfg_repeat;

	// [0] up step, [1] down step
	logic [1:0]       step_queue [$];

	logic [NOW_W-1:0] clock_ms;
	int               run_left [NUM_KEYS];
	logic             target [NUM_KEYS];
	bit               tx_idle_en;
	bit               rx_idle_en;
	bit               hold_off_req;
	int               errors;

	two_key_debounce_autorepeat uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial forever #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic advance_key(input int idx, input logic level,
			input logic [NOW_W-1:0] now);
		key_track_t       ks;
		logic             pressed;
		logic             step;
		logic [NOW_W-1:0] held;
		ks = key_st[idx];
		pressed = (level == cfg_active);
		step = 1'b0;
		if (pressed == ks.prev_pressed) begin
			if (ks.agree < cfg_thresh)
				ks.agree = ks.agree + 1'b1;
		end else begin
			ks.prev_pressed = pressed;
			ks.agree = CNT_W'(1);
		end
		if (ks.agree < cfg_thresh || pressed == ks.stable) begin
			if (ks.stable) begin
				if (!ks.repeating) begin
					held = now - ks.press_t;
					if (held >= NOW_W'(cfg_long)) begin
						ks.repeating = 1'b1;
						ks.repeat_t = now;
						step = 1'b1;
					end
				end else begin
					held = now - ks.repeat_t;
					if (held >= NOW_W'(cfg_repeat)) begin
						ks.repeat_t = now;
						step = 1'b1;
					end
				end
			end
		end else begin
			ks.stable = pressed;
			ks.repeating = 1'b0;
			ks.press_t = now;
			ks.repeat_t = now;
			step = pressed;
		end
		key_st[idx] = ks;
		return step;
	endfunction

	// drop ready in random bursts, or for a long stretch on request
	initial forever begin
		@(posedge clk);
		if (hold_off_req) begin
			m_tready <= 1'b0;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
			hold_off_req = 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (step_queue.size() == 0) begin
				$display("%0t: result with none pending: expected nothing, actual %b",
					$time, m_tdata[1:0]);
				errors++;
			end else begin
				want = step_queue.pop_front();
				if (m_tdata[0] !== want[0]) begin
					$display("%0t: up_step mismatch: expected %b, actual %b",
						$time, want[0], m_tdata[0]);
					errors++;
				end
				if (m_tdata[1] !== want[1]) begin
					$display("%0t: down_step mismatch: expected %b, actual %b",
						$time, want[1], m_tdata[1]);
					errors++;
				end
			end
		end
	end

	task automatic send_poll(input logic up_lvl, input logic up_ok, input logic dn_lvl,
			input logic dn_ok, input logic [NOW_W-1:0] now);
		logic [1:0] steps;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - NOW_W - 4){1'b0}}, now, dn_ok, dn_lvl, up_ok, up_lvl};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		steps = 2'b00;
		if (up_ok)
			steps[0] = advance_key(KEY_UP, up_lvl, now);
		if (dn_ok)
			steps[1] = advance_key(KEY_DOWN, dn_lvl, now);
		step_queue.push_back(steps);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (step_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_PRESS_LEVEL: cfg_active = value[0];
			REG_THRESHOLD:   cfg_thresh = value[CNT_W-1:0];
			REG_LONG_PRESS:  cfg_long   = value[MS_W-1:0];
			REG_REPEAT:      cfg_repeat = value[MS_W-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic active, input int thresh, input int long_ms,
			input int rep_ms);
		write_reg(REG_PRESS_LEVEL, APB_DATA_W'(active));
		write_reg(REG_THRESHOLD, APB_DATA_W'(thresh));
		write_reg(REG_LONG_PRESS, APB_DATA_W'(long_ms));
		write_reg(REG_REPEAT, APB_DATA_W'(rep_ms));
	endtask

	// held levels with bounce, failed reads and occasional random noise
	task automatic random_polls(input int count, input int max_dt);
		logic lvl [NUM_KEYS];
		logic ok [NUM_KEYS];
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
				continue;
			end
			clock_ms = clock_ms + $urandom_range(0, max_dt);
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (run_left[k] == 0) begin
					target[k] = ($urandom_range(0, 4) == 0) ? target[k] : ~target[k];
					run_left[k] = $urandom_range(1, 40);
				end
				run_left[k]--;
				lvl[k] = target[k] ^ ($urandom_range(0, 9) == 0);
				ok[k] = ($urandom_range(0, 9) != 0);
			end
			send_poll(lvl[0], ok[0], lvl[1], ok[1], clock_ms);
		end
	endtask

	task automatic test_directed_defaults();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'd0);
		send_poll(1'b0, 1'b1, 1'b0, 1'b0, 32'd10);
		send_poll(1'b0, 1'b1, 1'b0, 1'b0, 32'd20);
		send_poll(1'b0, 1'b1, 1'b1, 1'b0, 32'd30);
		send_poll(1'b0, 1'b1, 1'b1, 1'b1, 32'd100);
		send_poll(1'b0, 1'b1, 1'b1, 1'b1, 32'd530);
		send_poll(1'b0, 1'b1, 1'b1, 1'b1, 32'd649);
		send_poll(1'b0, 1'b1, 1'b1, 1'b1, 32'd650);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'd700);
		send_poll(1'b0, 1'b1, 1'b1, 1'b1, 32'd800);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'd810);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'd820);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'd830);
		send_poll(1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FF00);
		send_poll(1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FF80);
		send_poll(1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b1, 1'b0, 1'b0, 1'b1, 32'h0000_01F3);
	endtask

	task automatic test_zero_threshold_and_delays();
		wait_drained();
		set_config(1'b1, 0, 0, 0);
		send_poll(1'b1, 1'b1, 1'b0, 1'b1, 32'd5);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'd5);
		send_poll(1'b1, 1'b1, 1'b1, 1'b1, 32'd6);
		send_poll(1'b0, 1'b1, 1'b1, 1'b0, 32'd6);
		send_poll(1'b1, 1'b1, 1'b0, 1'b1, 32'hAAAA_5555);
		send_poll(1'b1, 1'b0, 1'b1, 1'b1, 32'h5555_AAAA);
	endtask

	task automatic test_random_defaults();
		wait_drained();
		set_config(1'b0, THRESHOLD_RST, LONG_PRESS_RST, REPEAT_RST);
		clock_ms = $urandom();
		random_polls(110, 60);
	endtask

	task automatic test_random_slow_debounce();
		wait_drained();
		set_config(1'b1, 15, 200, 50);
		clock_ms = 32'hFFFF_F000;
		random_polls(90, 30);
	endtask

	task automatic test_random_long_delays();
		wait_drained();
		set_config(1'b0, 1, 65535, 65535);
		clock_ms = 32'hFFF0_0000;
		random_polls(80, 40000);
		wait_drained();
		set_config(1'b1, 0, 0, 0);
		random_polls(40, 10);
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		set_config(1'b0, 2, 100, 30);
		tx_idle_en = 1'b0;
		hold_off_req = 1'b1;
		random_polls(60, 40);
		wait_drained();
		tx_idle_en = 1'b1;
		random_polls(40, 40);
	endtask

	task automatic test_back_to_back();
		wait_drained();
		set_config(1'b1, 4, 80, 0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		clock_ms = $urandom();
		random_polls(120, 50);
	endtask

	initial begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_st[k] = '0;
			run_left[k] = 0;
			target[k] = 1'b1;
		end
		cfg_active = 1'b0;
		cfg_thresh = THRESHOLD_RST;
		cfg_long = LONG_PRESS_RST;
		cfg_repeat = REPEAT_RST;
		errors = 0;
		hold_off_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_zero_threshold_and_delays();
		test_random_defaults();
		test_random_slow_debounce();
		test_random_long_delays();
		test_output_backpressure();
		test_back_to_back();
		wait_drained();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/tkda_pkg.sv
src/two_key_debounce_autorepeat.sv
dv/two_key_debounce_autorepeat_test.sv
